// File: hdl/rofb_pkg.sv
// ----------------------------------------------------------------------------
// rofb_pkg
// Shared widths, codes and types of the raster-operation framebuffer.
// ----------------------------------------------------------------------------
`default_nettype none

package rofb_pkg;

  // Default store dimensions.
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Field widths.
  localparam int OFFSET_W   = 20;
  localparam int PIXEL_W    = 8;
  localparam int STATUS_W   = 2;
  localparam int DIM_W      = 11;
  localparam int POS_W      = 10;
  localparam int ROP_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  // Width of the linear address sum before it is cut to the store depth.
  localparam int LIN_W      = 24;

  // Result status codes.
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_VIEW  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  // Raster operations.
  typedef logic [ROP_W-1:0] rop_t;
  localparam rop_t ROP_SET = 3'd0;
  localparam rop_t ROP_ADD = 3'd1;
  localparam rop_t ROP_SUB = 3'd2;
  localparam rop_t ROP_AND = 3'd3;
  localparam rop_t ROP_OR  = 3'd4;
  localparam rop_t ROP_XOR = 3'd5;

  // Access kind.
  localparam logic OP_WRITE = 1'b1;

  // Register indexes.
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FB_WIDTH    = 3'd0;
  localparam cfg_idx_t CFG_FB_HEIGHT   = 3'd1;
  localparam cfg_idx_t CFG_VIEW_X      = 3'd2;
  localparam cfg_idx_t CFG_VIEW_Y      = 3'd3;
  localparam cfg_idx_t CFG_VIEW_WIDTH  = 3'd4;
  localparam cfg_idx_t CFG_VIEW_HEIGHT = 3'd5;
  localparam cfg_idx_t CFG_RASTER_OP   = 3'd6;

  // Register reset values.
  localparam logic [DIM_W-1:0] FB_WIDTH_RST    = 11'd1000;
  localparam logic [DIM_W-1:0] FB_HEIGHT_RST   = 11'd1000;
  localparam logic [DIM_W-1:0] VIEW_WIDTH_RST  = 11'd1000;
  localparam logic [DIM_W-1:0] VIEW_HEIGHT_RST = 11'd1000;

  // Configuration as seen by the front and back parts; pitch and rows are
  // already clipped to the store size.
  typedef struct packed {
    logic [DIM_W-1:0] pitch;
    logic [DIM_W-1:0] rows;
    logic [POS_W-1:0] view_x;
    logic [POS_W-1:0] view_y;
    logic [DIM_W-1:0] view_width;
    logic [DIM_W-1:0] view_height;
    rop_t             raster_op;
  } cfg_t;

  // Classified job handed from the front part to the back part.
  typedef struct packed {
    logic                op;
    logic [OFFSET_W-1:0] offset;
    logic [PIXEL_W-1:0]  pixel;
    logic                eot;
    status_t             status;
  } job_t;

endpackage

`default_nettype wire

// File: hdl/rofb_if.sv
// ----------------------------------------------------------------------------
// rofb channel interfaces
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rofb_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [rofb_pkg::OFFSET_W-1:0] offset;
  logic [rofb_pkg::PIXEL_W-1:0]  pixel_in;
  logic                          end_of_transfer;

  modport source (output valid, operation, offset, pixel_in, end_of_transfer,
                  input ready);
  modport sink   (input valid, operation, offset, pixel_in, end_of_transfer,
                  output ready);
endinterface

interface rofb_out_if;
  logic                          valid;
  logic                          ready;
  logic [rofb_pkg::PIXEL_W-1:0]  pixel_out;
  logic [rofb_pkg::STATUS_W-1:0] status;
  logic                          transfer_done;

  modport source (output valid, pixel_out, status, transfer_done, input ready);
  modport sink   (input valid, pixel_out, status, transfer_done, output ready);
endinterface

interface rofb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rofb_pkg::CFG_IDX_W-1:0]  index;
  logic [rofb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/rofb_regs.sv
// ----------------------------------------------------------------------------
// rofb_regs
// Configuration register file; clips the framebuffer size to the store.
// ----------------------------------------------------------------------------
`default_nettype none

module rofb_regs #(
  parameter int MAX_WIDTH  = rofb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rofb_pkg::MAX_HEIGHT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  rofb_cfg_if.sink       cfg_wr,
  output rofb_pkg::cfg_t cfg
);
  import rofb_pkg::*;

  logic [DIM_W-1:0] fb_width;
  logic [DIM_W-1:0] fb_height;
  logic [POS_W-1:0] view_x;
  logic [POS_W-1:0] view_y;
  logic [DIM_W-1:0] view_width;
  logic [DIM_W-1:0] view_height;
  rop_t             raster_op;

  // Writes are always taken.
  assign cfg_wr.ready = 1'b1;

  // Register writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      fb_width    <= FB_WIDTH_RST;
      fb_height   <= FB_HEIGHT_RST;
      view_x      <= '0;
      view_y      <= '0;
      view_width  <= VIEW_WIDTH_RST;
      view_height <= VIEW_HEIGHT_RST;
      raster_op   <= ROP_SET;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        CFG_FB_WIDTH:    fb_width    <= cfg_wr.data[DIM_W-1:0];
        CFG_FB_HEIGHT:   fb_height   <= cfg_wr.data[DIM_W-1:0];
        CFG_VIEW_X:      view_x      <= cfg_wr.data[POS_W-1:0];
        CFG_VIEW_Y:      view_y      <= cfg_wr.data[POS_W-1:0];
        CFG_VIEW_WIDTH:  view_width  <= cfg_wr.data[DIM_W-1:0];
        CFG_VIEW_HEIGHT: view_height <= cfg_wr.data[DIM_W-1:0];
        CFG_RASTER_OP:   raster_op   <= cfg_wr.data[ROP_W-1:0];
        default: ;
      endcase
    end
  end

  // A framebuffer larger than the store counts as the store size.
  always_comb begin
    cfg.pitch       = (int'(fb_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : fb_width;
    cfg.rows        = (int'(fb_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : fb_height;
    cfg.view_x      = view_x;
    cfg.view_y      = view_y;
    cfg.view_width  = view_width;
    cfg.view_height = view_height;
    cfg.raster_op   = raster_op;
  end

endmodule

`default_nettype wire

// File: hdl/rofb_front.sv
// ----------------------------------------------------------------------------
// rofb_front
// Accepts requests, checks the viewport and the offset, and queues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module rofb_front (
  input  logic           clk,
  input  logic           rst,
  input  rofb_pkg::cfg_t cfg,
  input  logic           clearing,
  rofb_in_if.sink        req,
  input  logic           full,
  output logic           push,
  output rofb_pkg::job_t job
);
  import rofb_pkg::*;

  logic                hold_valid;
  logic                hold_op;
  logic [OFFSET_W-1:0] hold_offset;
  logic [PIXEL_W-1:0]  hold_pixel;
  logic                hold_eot;
  logic [DIM_W:0]      x_end;
  logic [DIM_W:0]      y_end;
  logic [2*DIM_W-1:0]  area;
  logic                accept;

  assign accept    = req.valid && req.ready;
  assign push      = hold_valid && !full;
  // No requests while the store is being cleared after reset.
  assign req.ready = !clearing && (!hold_valid || !full);

  // Holding register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  // Holding register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_op     <= req.operation;
      hold_offset <= req.offset;
      hold_pixel  <= req.pixel_in;
      hold_eot    <= req.end_of_transfer;
    end
  end

  // Classification: the viewport must fit, and the offset must lie inside it.
  // A zero viewport width or height gives a zero area, so every offset fails.
  always_comb begin
    x_end = (DIM_W+1)'(cfg.view_x) + (DIM_W+1)'(cfg.view_width);
    y_end = (DIM_W+1)'(cfg.view_y) + (DIM_W+1)'(cfg.view_height);
    area  = (2*DIM_W)'(cfg.view_width) * (2*DIM_W)'(cfg.view_height);
    job.op     = hold_op;
    job.offset = hold_offset;
    job.pixel  = hold_pixel;
    job.eot    = hold_eot;
    priority if ((x_end > (DIM_W+1)'(cfg.pitch)) || (y_end > (DIM_W+1)'(cfg.rows))) begin
      job.status = ST_VIEW;
    end else if ((2*DIM_W)'(hold_offset) >= area) begin
      job.status = ST_RANGE;
    end else begin
      job.status = ST_OK;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rofb_fifo.sv
// ----------------------------------------------------------------------------
// rofb_fifo
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module rofb_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rofb_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output rofb_pkg::job_t head,
  output logic           empty
);
  import rofb_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = (count == (PTR_W+1)'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rofb_back.sv
// ----------------------------------------------------------------------------
// rofb_back
// Divides the offset by the viewport width, forms the store address and
// performs the pixel read or read-modify-write; owns the frame store.
// ----------------------------------------------------------------------------
`default_nettype none

module rofb_back #(
  parameter int MAX_WIDTH  = rofb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rofb_pkg::MAX_HEIGHT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  rofb_pkg::cfg_t cfg,
  input  logic           empty,
  input  rofb_pkg::job_t head,
  output logic           pop,
  output logic           clearing,
  rofb_out_if.source     rsp
);
  import rofb_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int STEP_W = $clog2(OFFSET_W);
  localparam logic [PIXEL_W-1:0] PIX_MAX = 8'd255;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_ADDR  = 7'b0010000,
    S_READ  = 7'b0100000,
    S_WRITE = 7'b1000000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [ADDR_W-1:0]   clr_addr;
  logic                cur_op;
  logic [PIXEL_W-1:0]  cur_pixel;
  logic                cur_eot;
  logic [OFFSET_W-1:0] quo;
  logic [DIM_W-1:0]    rem;
  logic [STEP_W-1:0]   step;
  logic [DIM_W:0]      shifted;
  logic [DIM_W:0]      diff;
  logic                fits;
  logic [2*DIM_W:0]    prod;
  logic [LIN_W-1:0]    lin;
  logic [ADDR_W-1:0]   addr;
  logic [PIXEL_W-1:0]  rd_pixel;
  logic [PIXEL_W-1:0]  new_pixel;
  logic [PIXEL_W-1:0]  result_pixel;
  logic                res_valid;
  logic [PIXEL_W-1:0]  res_pixel;
  status_t             res_status;
  logic                res_eot;
  logic                res_free;
  logic                finish;
  logic                reject;
  logic                mem_we;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_addr;
  logic [PIXEL_W-1:0]  mem_wdata;
  logic [PIXEL_W-1:0]  mem [DEPTH];

  // Combine the source byte with the stored pixel; unknown codes keep it.
  function automatic logic [PIXEL_W-1:0] combine(input rop_t op,
                                                 input logic [PIXEL_W-1:0] old,
                                                 input logic [PIXEL_W-1:0] src);
    logic [PIXEL_W:0]   sum;
    logic [PIXEL_W-1:0] res;
    sum = (PIXEL_W+1)'(old) + (PIXEL_W+1)'(src);
    unique case (op)
      ROP_SET: res = src;
      ROP_ADD: res = sum[PIXEL_W] ? PIX_MAX : sum[PIXEL_W-1:0];
      ROP_SUB: res = (old < src) ? '0 : old - src;
      ROP_AND: res = old & src;
      ROP_OR:  res = old | src;
      ROP_XOR: res = old ^ src;
      default: res = old;
    endcase
    return res;
  endfunction

  // Handshake toward the output register and the queue.
  assign res_free = !res_valid || rsp.ready;
  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && !empty && res_free;
  assign reject   = pop && (head.status != ST_OK);
  assign finish   = (state == S_WRITE) && res_free;

  // Restoring divider step: one quotient bit per cycle, MSB first.
  assign shifted = {rem, quo[OFFSET_W-1]};
  assign fits    = (shifted >= (DIM_W+1)'(cfg.view_width));
  assign diff    = shifted - (DIM_W+1)'(cfg.view_width);

  // Linear address: row base from the product, plus left column and column.
  assign lin = LIN_W'(prod) + LIN_W'(cfg.view_x) + LIN_W'(rem);

  assign new_pixel    = combine(cfg.raster_op, rd_pixel, cur_pixel);
  assign result_pixel = (cur_op == OP_WRITE) ? new_pixel : rd_pixel;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH-1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop && (head.status == ST_OK)) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (step == STEP_W'(OFFSET_W-1)) begin
          state_next = S_MUL;
        end
      end
      S_MUL:   state_next = S_ADDR;
      S_ADDR:  state_next = S_READ;
      S_READ:  state_next = S_WRITE;
      S_WRITE: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Clearing sweep address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Job datapath: load, divide, multiply, address.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_op    <= head.op;
      cur_pixel <= head.pixel;
      cur_eot   <= head.eot;
      quo       <= head.offset;
      rem       <= '0;
      step      <= '0;
    end else if (state == S_DIV) begin
      quo  <= {quo[OFFSET_W-2:0], fits};
      rem  <= fits ? diff[DIM_W-1:0] : shifted[DIM_W-1:0];
      step <= step + 1'b1;
    end
    // The row is below the viewport height, so it fits in DIM_W bits.
    if (state == S_MUL) begin
      prod <= (2*DIM_W+1)'((DIM_W+1)'(cfg.view_y) + (DIM_W+1)'(quo[DIM_W-1:0]))
              * (2*DIM_W+1)'(cfg.pitch);
    end
    if (state == S_ADDR) begin
      addr <= ADDR_W'(lin);
    end
  end

  // Frame store port: the clearing sweep, the pixel read and the write back.
  always_comb begin
    mem_we    = clearing || (finish && (cur_op == OP_WRITE));
    mem_re    = (state == S_READ);
    mem_addr  = clearing ? clr_addr : addr;
    mem_wdata = clearing ? '0 : new_pixel;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_pixel <= mem[mem_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (reject || finish) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (reject) begin
      res_pixel  <= '0;
      res_status <= head.status;
      res_eot    <= head.eot;
    end else if (finish) begin
      res_pixel  <= result_pixel;
      res_status <= ST_OK;
      res_eot    <= cur_eot;
    end
  end

  assign rsp.valid         = res_valid;
  assign rsp.pixel_out     = res_pixel;
  assign rsp.status        = res_status;
  assign rsp.transfer_done = res_eot;

endmodule

`default_nettype wire

// File: hdl/viewport_raster_op_framebuffer_unit.sv
// ----------------------------------------------------------------------------
// viewport_raster_op_framebuffer_unit
// Byte framebuffer with a viewport window and raster-operation writes.
// ----------------------------------------------------------------------------
// After reset the unit clears the whole store, one pixel a cycle; req.ready
// stays low until the sweep ends, while configuration writes are taken at any
// time. A request whose viewport or offset fails the bounds check returns its
// word from the idle state without entering the divider. A valid read or write
// runs a bit-serial divider, then a multiply, an address add, a store read and,
// for a write, a write back; the back end takes no new job until that result
// has been handed to the output register. A two-entry queue lets new requests
// be taken while the back end is busy. Configuration may be changed only while
// no request is in flight.
`default_nettype none

module viewport_raster_op_framebuffer_unit #(
  parameter int MAX_WIDTH  = rofb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rofb_pkg::MAX_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  rofb_cfg_if.sink   cfg,
  rofb_in_if.sink    req,
  rofb_out_if.source rsp
);
  import rofb_pkg::*;

  cfg_t cfg_val;
  job_t push_job;
  job_t head;
  logic push;
  logic full;
  logic pop;
  logic empty;
  logic clearing;

  rofb_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg_wr (cfg),
    .cfg    (cfg_val)
  );

  rofb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_val),
    .clearing (clearing),
    .req      (req),
    .full     (full),
    .push     (push),
    .job      (push_job)
  );

  rofb_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  rofb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_val),
    .empty    (empty),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

// File: hdl/rofb_checker.sv
// ----------------------------------------------------------------------------
// rofb_checker
// Port-level assertions for the framebuffer unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rofb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [rofb_pkg::PIXEL_W-1:0]  rsp_pixel_out,
  input logic [rofb_pkg::STATUS_W-1:0] rsp_status,
  input logic                          rsp_transfer_done
);
  import rofb_pkg::*;

  logic       req_acc;
  logic       rsp_acc;
  logic [2:0] pending;

  assign req_acc = req_valid && req_ready;
  assign rsp_acc = rsp_valid && rsp_ready;

  // Requests taken whose word has not yet been delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (req_acc && !rsp_acc) begin
      pending <= pending + 1'b1;
    end else if (rsp_acc && !req_acc) begin
      pending <= pending - 1'b1;
    end
  end

  // A stalled response stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // A stalled response keeps its payload.
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      $stable(rsp_pixel_out) && $stable(rsp_status) && $stable(rsp_transfer_done))
    else $error("response payload changed while stalled");

  // A rejected access never reports pixel data.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ST_OK) |-> rsp_pixel_out == '0)
    else $error("rejected access returned a nonzero pixel");

  // Every word answers a request taken earlier.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != '0)
    else $error("response without an outstanding request");

endmodule

bind viewport_raster_op_framebuffer_unit rofb_checker u_rofb_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_pixel_out     (rsp.pixel_out),
  .rsp_status        (rsp.status),
  .rsp_transfer_done (rsp.transfer_done)
);

`default_nettype wire
